// ===== hw/rtl/nmcf_pkg.sv =====
// Shared types and constants of the network-management channel state machine.
// No dependencies; used by nmcf_cell and network_management_channel_fsm.
package nmcf_pkg;

    typedef enum logic [2:0] {
        OP_REQUEST = 3'd0,
        OP_RELEASE = 3'd1,
        OP_MSG     = 3'd2,
        OP_RSLEEP  = 3'd3,
        OP_REPEAT  = 3'd4,
        OP_TICK    = 3'd5,
        OP_STATUS  = 3'd6,
        OP_CLUSTER = 3'd7
    } nmcf_op_t;

    typedef enum logic [2:0] {
        CS_BUS    = 3'd0,
        CS_PREP   = 3'd1,
        CS_READY  = 3'd2,
        CS_NORMAL = 3'd3,
        CS_REPEAT = 3'd4
    } nmcf_cstate_t;

    typedef enum logic [1:0] {
        K_ACK     = 2'd0,
        K_CHANGE  = 2'd1,
        K_INVALID = 2'd2,
        K_STATUS  = 2'd3
    } nmcf_kind_t;

    typedef enum logic [1:0] {
        MD_BUS   = 2'd0,
        MD_PREP  = 2'd1,
        MD_NET   = 2'd2,
        MD_UNUSED = 2'd3
    } nmcf_mode_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_OP,
        F_ACK,
        F_TICK,
        F_DONE
    } nmcf_fsm_t;

    localparam logic [2:0] CFG_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_REPEAT  = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_WAITBS  = 3'd3;
    localparam logic [2:0] CFG_NOTIFY  = 3'd4;

    typedef struct packed {
        nmcf_op_t    op;
        logic [2:0]  channel;
        logic [31:0] now_ms;
    } nmcf_item_t;

    typedef struct packed {
        logic [2:0]  chan_out;
        nmcf_kind_t  kind;
        logic [2:0]  old_state;
        logic [2:0]  new_state;
        logic [1:0]  mode;
        logic        requested;
        logic [31:0] wakeup_count;
        logic [31:0] repeat_count;
        logic [31:0] timeout_count;
        logic [31:0] sleep_count;
        logic        cluster_ready;
        logic        last;
    } nmcf_res_t;

    // Control from the sequencer to one cell.
    typedef struct packed {
        logic     go;
        logic     tick;
        nmcf_op_t op;
    } nmcf_ctl_t;

    // What a cell shows to the sequencer.
    typedef struct packed {
        nmcf_cstate_t state;
        logic         req;
        logic [31:0]  wake;
        logic [31:0]  rep;
        logic [31:0]  tmo;
        logic [31:0]  sleep;
        nmcf_cstate_t nxt;
        logic         chg;
    } nmcf_cst_t;

    function automatic logic [1:0] mode_of(input nmcf_cstate_t s);
        logic [1:0] m;
        case (s)
            CS_BUS:  m = MD_BUS;
            CS_PREP: m = MD_PREP;
            CS_READY, CS_NORMAL, CS_REPEAT: m = MD_NET;
            default: m = MD_BUS;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/nmcf_cell.sv =====
// One channel cell: the channel's state, flags, timestamps and event counters.
// Depends on nmcf_pkg. Cells are chained for the cluster-ready summary.
module nmcf_cell #(
    parameter int TW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                en,
    input  nmcf_pkg::nmcf_ctl_t ctl,
    input  logic [TW-1:0]       now,
    input  logic [TW-1:0]       stamp,
    input  logic [31:0]         rmt,
    input  logic [31:0]         nmt,
    input  logic [31:0]         wbs,
    input  logic                any_in,
    input  logic                ok_in,
    output logic                any_out,
    output logic                ok_out,
    output nmcf_pkg::nmcf_cst_t st
);

    nmcf_pkg::nmcf_cstate_t state_reg;
    logic                   req_reg;
    logic                   msg_reg;
    logic [TW-1:0]          ent_reg;
    logic [TW-1:0]          lmsg_reg;
    logic [31:0]            wake_reg;
    logic [31:0]            rep_reg;
    logic [31:0]            tmo_reg;
    logic [31:0]            sleep_reg;

    nmcf_pkg::nmcf_cstate_t tick_ns;
    nmcf_pkg::nmcf_cstate_t op_ns;
    nmcf_pkg::nmcf_cstate_t nxt;
    logic                   tick_msg;
    logic [TW-1:0]          tick_lm;
    logic                   op_req;
    logic                   op_msg;
    logic                   inc_wake;
    logic                   inc_rep;
    logic                   inc_tmo;
    logic                   inc_sleep;
    logic [TW-1:0]          el;
    logic [TW-1:0]          elm;
    logic [TW-1:0]          ml;
    logic [TW-1:0]          stamp_sel;

    // Elapsed time that stops at zero when time runs backwards.
    function automatic logic [TW-1:0] since(input logic [TW-1:0] a, input logic [TW-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    always_comb
    begin
        el        = since(now, ent_reg);
        ml        = msg_reg ? now : lmsg_reg;
        elm       = since(now, ml);
        tick_ns   = state_reg;
        tick_msg  = msg_reg;
        tick_lm   = lmsg_reg;
        inc_wake  = 1'b0;
        inc_rep   = 1'b0;
        inc_tmo   = 1'b0;
        inc_sleep = 1'b0;
        unique case (state_reg)
            nmcf_pkg::CS_BUS:
            begin
                if (req_reg || msg_reg)
                begin
                    tick_msg = 1'b0;
                    inc_wake = 1'b1;
                    tick_ns  = nmcf_pkg::CS_REPEAT;
                end
            end
            nmcf_pkg::CS_REPEAT:
            begin
                tick_msg = 1'b0;
                tick_lm  = now;
                inc_rep  = 1'b1;
                if (32'(el) >= rmt)
                    tick_ns = req_reg ? nmcf_pkg::CS_NORMAL : nmcf_pkg::CS_READY;
            end
            nmcf_pkg::CS_NORMAL:
            begin
                tick_msg = 1'b0;
                tick_lm  = ml;
                if (!req_reg)
                    tick_ns = nmcf_pkg::CS_READY;
                else if (32'(elm) >= nmt)
                begin
                    inc_tmo = 1'b1;
                    tick_ns = nmcf_pkg::CS_REPEAT;
                end
            end
            nmcf_pkg::CS_READY:
            begin
                if (req_reg || msg_reg)
                begin
                    tick_msg = 1'b0;
                    tick_ns  = nmcf_pkg::CS_NORMAL;
                end
                else if (32'(el) >= nmt)
                    tick_ns = nmcf_pkg::CS_PREP;
            end
            nmcf_pkg::CS_PREP:
            begin
                if (req_reg || msg_reg)
                begin
                    tick_msg = 1'b0;
                    tick_ns  = nmcf_pkg::CS_REPEAT;
                end
                else if (32'(el) >= wbs)
                begin
                    inc_sleep = 1'b1;
                    tick_ns   = nmcf_pkg::CS_BUS;
                end
            end
            default: tick_ns = state_reg;
        endcase

        op_ns  = state_reg;
        op_req = req_reg;
        op_msg = msg_reg;
        case (ctl.op)
            nmcf_pkg::OP_REQUEST: op_req = 1'b1;
            nmcf_pkg::OP_RELEASE: op_req = 1'b0;
            nmcf_pkg::OP_MSG:     op_msg = 1'b1;
            nmcf_pkg::OP_RSLEEP:
            begin
                if (!req_reg && (state_reg == nmcf_pkg::CS_READY ||
                                 state_reg == nmcf_pkg::CS_NORMAL))
                    op_ns = nmcf_pkg::CS_PREP;
            end
            nmcf_pkg::OP_REPEAT:
            begin
                if (state_reg != nmcf_pkg::CS_BUS)
                    op_ns = nmcf_pkg::CS_REPEAT;
            end
            default: op_ns = state_reg;
        endcase

        nxt       = ctl.tick ? tick_ns : op_ns;
        stamp_sel = ctl.tick ? now : stamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nmcf_pkg::CS_BUS;
            req_reg   <= 1'b0;
            msg_reg   <= 1'b0;
            ent_reg   <= '0;
            lmsg_reg  <= '0;
            wake_reg  <= '0;
            rep_reg   <= '0;
            tmo_reg   <= '0;
            sleep_reg <= '0;
        end
        else if (clr)
        begin
            state_reg <= nmcf_pkg::CS_BUS;
            req_reg   <= 1'b0;
            msg_reg   <= 1'b0;
            ent_reg   <= '0;
            lmsg_reg  <= '0;
            wake_reg  <= '0;
            rep_reg   <= '0;
            tmo_reg   <= '0;
            sleep_reg <= '0;
        end
        else if (ctl.go)
        begin
            state_reg <= nxt;
            if (nxt != state_reg)
                ent_reg <= stamp_sel;
            if (ctl.tick)
            begin
                msg_reg  <= tick_msg;
                lmsg_reg <= tick_lm;
                if (inc_wake)
                    wake_reg <= wake_reg + 32'd1;
                if (inc_rep)
                    rep_reg <= rep_reg + 32'd1;
                if (inc_tmo)
                    tmo_reg <= tmo_reg + 32'd1;
                if (inc_sleep)
                    sleep_reg <= sleep_reg + 32'd1;
            end
            else
            begin
                req_reg <= op_req;
                msg_reg <= op_msg;
            end
        end
    end

    assign any_out = any_in | en;
    assign ok_out  = ok_in & (!en || state_reg == nmcf_pkg::CS_BUS ||
                              state_reg == nmcf_pkg::CS_PREP ||
                              state_reg == nmcf_pkg::CS_READY);

    assign st.state = state_reg;
    assign st.req   = req_reg;
    assign st.wake  = wake_reg;
    assign st.rep   = rep_reg;
    assign st.tmo   = tmo_reg;
    assign st.sleep = sleep_reg;
    assign st.nxt   = nxt;
    assign st.chg   = (nxt != state_reg);

endmodule

// ===== hw/rtl/network_management_channel_fsm.sv =====
// Top level of the network-management channel state machine: sequencer,
// configuration registers, result register. Depends on nmcf_pkg, nmcf_cell.
//
// Use: requests arrive on item (item_valid / item_stall); results leave on
// res (res_valid / res_stall); res.last marks the final result of a request.
// Configuration is written on cfg_valid / cfg_ready (always ready) with
// cfg_index selecting the register; indexes past the list are ignored.
// Every channel lives in its own cell of a chain; the cells also pass the
// cluster-ready summary from one to the next.
// A request is taken in F_IDLE; all but a tick are handled in F_OP. Ops 0-4
// need two result slots (optional notification, then the ack) and go on to
// F_ACK; status, cluster query and invalid-channel answers need one. A tick
// visits one cell per cycle unless stalled, then ends in F_DONE (at most 8
// cells are addressable). The sequencer handles one request at a time and
// stalls item until the request's last result is in the result register.
// A stalled result holds the register and the sequencer in place. Reset
// clears every channel to bus sleep with zero counters and loads the
// configuration defaults; the block is ready right after reset.
module network_management_channel_fsm #(
    parameter int NUM_CHANNELS = 8,
    parameter int TIME_BITS    = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  nmcf_pkg::nmcf_item_t item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output nmcf_pkg::nmcf_res_t  res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    // Only eight channel indexes exist; stored times never exceed the
    // 32-bit input time.
    localparam int NCELL = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
    localparam int IW    = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int TW    = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam logic [3:0]    NC4  = 4'(NCELL);
    localparam logic [IW-1:0] LAST = IW'(NCELL - 1);

    nmcf_pkg::nmcf_fsm_t fsm_reg;
    nmcf_pkg::nmcf_fsm_t fsm_next;
    nmcf_pkg::nmcf_op_t  op_reg;
    logic [2:0]          ch_reg;
    logic [TW-1:0]       now_reg;
    logic [TW-1:0]       ltt_reg;
    logic [IW-1:0]       idx_reg;
    logic [IW-1:0]       idx_next;
    nmcf_pkg::nmcf_res_t out_reg;
    nmcf_pkg::nmcf_res_t out_next;
    logic                out_vld_reg;
    logic                load;

    logic [7:0]          en_reg;
    logic [31:0]         rmt_reg;
    logic [31:0]         nmt_reg;
    logic [31:0]         wbs_reg;
    logic                ntf_reg;

    logic                item_acc;
    logic                cfg_we;
    logic                slot_free;
    logic                go_all;
    logic [IW-1:0]       sel;
    logic                ch_live;
    logic                sel_live;
    logic [NCELL-1:0]    en_c;

    nmcf_pkg::nmcf_cst_t st [NCELL];
    nmcf_pkg::nmcf_cst_t st_sel;
    logic                any_c [NCELL+1];
    logic                ok_c  [NCELL+1];

    assign item_acc   = item_valid && !item_stall;
    assign item_stall = (fsm_reg != nmcf_pkg::F_IDLE);
    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign slot_free  = !out_vld_reg || !res_stall;
    assign res_valid  = out_vld_reg;
    assign res        = out_reg;

    assign en_c     = en_reg[NCELL-1:0];
    assign ch_live  = ({1'b0, ch_reg} < NC4) && en_c[ch_reg[IW-1:0]];
    assign sel      = (fsm_reg == nmcf_pkg::F_TICK) ? idx_reg : ch_reg[IW-1:0];
    assign st_sel   = st[sel];
    assign sel_live = en_c[idx_reg];

    assign any_c[0] = 1'b0;
    assign ok_c[0]  = 1'b1;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        nmcf_pkg::nmcf_ctl_t ctl;
        logic                clr;

        assign clr      = cfg_we && (cfg_index == nmcf_pkg::CFG_ENABLE) &&
                          (cfg_data[i] ^ en_reg[i]);
        assign ctl.go   = go_all && (sel == IW'(i));
        assign ctl.tick = (fsm_reg == nmcf_pkg::F_TICK);
        assign ctl.op   = op_reg;

        nmcf_cell #(.TW(TW)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clr     (clr),
            .en      (en_c[i]),
            .ctl     (ctl),
            .now     (now_reg),
            .stamp   (ltt_reg),
            .rmt     (rmt_reg),
            .nmt     (nmt_reg),
            .wbs     (wbs_reg),
            .any_in  (any_c[i]),
            .ok_in   (ok_c[i]),
            .any_out (any_c[i+1]),
            .ok_out  (ok_c[i+1]),
            .st      (st[i])
        );
    end

    // Next state of the sequencer.
    always_comb
    begin
        fsm_next = fsm_reg;
        idx_next = idx_reg;
        unique case (fsm_reg)
            nmcf_pkg::F_IDLE:
            begin
                if (item_acc)
                begin
                    idx_next = '0;
                    fsm_next = (item.op == nmcf_pkg::OP_TICK) ? nmcf_pkg::F_TICK
                                                              : nmcf_pkg::F_OP;
                end
            end
            nmcf_pkg::F_OP:
            begin
                if (slot_free)
                begin
                    if (op_reg == nmcf_pkg::OP_CLUSTER || !ch_live ||
                        op_reg == nmcf_pkg::OP_STATUS)
                        fsm_next = nmcf_pkg::F_IDLE;
                    else
                        fsm_next = nmcf_pkg::F_ACK;
                end
            end
            nmcf_pkg::F_ACK:
            begin
                if (slot_free)
                    fsm_next = nmcf_pkg::F_IDLE;
            end
            nmcf_pkg::F_TICK:
            begin
                if (slot_free)
                begin
                    if (idx_reg == LAST)
                        fsm_next = nmcf_pkg::F_DONE;
                    else
                        idx_next = idx_reg + IW'(1);
                end
            end
            nmcf_pkg::F_DONE:
            begin
                if (slot_free)
                    fsm_next = nmcf_pkg::F_IDLE;
            end
            default: fsm_next = nmcf_pkg::F_IDLE;
        endcase
    end

    // Cell strobes and the result to load, per sequencer state.
    always_comb
    begin
        load     = 1'b0;
        go_all   = 1'b0;
        out_next = '0;
        unique case (fsm_reg)
            nmcf_pkg::F_OP:
            begin
                if (slot_free)
                begin
                    if (op_reg == nmcf_pkg::OP_CLUSTER)
                    begin
                        load                   = 1'b1;
                        out_next.cluster_ready = any_c[NCELL] && ok_c[NCELL];
                        out_next.last          = 1'b1;
                    end
                    else if (!ch_live)
                    begin
                        load              = 1'b1;
                        out_next.chan_out = ch_reg;
                        out_next.kind     = nmcf_pkg::K_INVALID;
                        out_next.last     = 1'b1;
                    end
                    else if (op_reg == nmcf_pkg::OP_STATUS)
                    begin
                        load                   = 1'b1;
                        out_next.chan_out      = ch_reg;
                        out_next.kind          = nmcf_pkg::K_STATUS;
                        out_next.old_state     = st_sel.state;
                        out_next.new_state     = st_sel.state;
                        out_next.mode          = nmcf_pkg::mode_of(st_sel.state);
                        out_next.requested     = st_sel.req;
                        out_next.wakeup_count  = st_sel.wake;
                        out_next.repeat_count  = st_sel.rep;
                        out_next.timeout_count = st_sel.tmo;
                        out_next.sleep_count   = st_sel.sleep;
                        out_next.last          = 1'b1;
                    end
                    else
                    begin
                        go_all = 1'b1;
                        if (st_sel.chg && ntf_reg)
                        begin
                            load               = 1'b1;
                            out_next.chan_out  = ch_reg;
                            out_next.kind      = nmcf_pkg::K_CHANGE;
                            out_next.old_state = st_sel.state;
                            out_next.new_state = st_sel.nxt;
                            out_next.mode      = nmcf_pkg::mode_of(st_sel.nxt);
                            out_next.requested = st_sel.req;
                        end
                    end
                end
            end
            nmcf_pkg::F_ACK:
            begin
                if (slot_free)
                begin
                    load               = 1'b1;
                    out_next.chan_out  = ch_reg;
                    out_next.kind      = nmcf_pkg::K_ACK;
                    out_next.old_state = st_sel.state;
                    out_next.new_state = st_sel.state;
                    out_next.mode      = nmcf_pkg::mode_of(st_sel.state);
                    out_next.requested = st_sel.req;
                    out_next.last      = 1'b1;
                end
            end
            nmcf_pkg::F_TICK:
            begin
                if (slot_free && sel_live)
                begin
                    go_all = 1'b1;
                    if (st_sel.chg && ntf_reg)
                    begin
                        load               = 1'b1;
                        out_next.chan_out  = 3'(idx_reg);
                        out_next.kind      = nmcf_pkg::K_CHANGE;
                        out_next.old_state = st_sel.state;
                        out_next.new_state = st_sel.nxt;
                        out_next.mode      = nmcf_pkg::mode_of(st_sel.nxt);
                        out_next.requested = st_sel.req;
                    end
                end
            end
            nmcf_pkg::F_DONE:
            begin
                if (slot_free)
                begin
                    load          = 1'b1;
                    out_next.last = 1'b1;
                end
            end
            default: load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg     <= nmcf_pkg::F_IDLE;
            idx_reg     <= '0;
            out_vld_reg <= 1'b0;
            ltt_reg     <= '0;
            en_reg      <= '0;
            rmt_reg     <= 32'd1500;
            nmt_reg     <= 32'd2000;
            wbs_reg     <= 32'd1500;
            ntf_reg     <= 1'b0;
        end
        else
        begin
            fsm_reg <= fsm_next;
            idx_reg <= idx_next;
            if (load)
                out_vld_reg <= 1'b1;
            else if (!res_stall)
                out_vld_reg <= 1'b0;
            if (item_acc && item.op == nmcf_pkg::OP_TICK)
                ltt_reg <= item.now_ms[TW-1:0];
            if (cfg_we)
            begin
                case (cfg_index)
                    nmcf_pkg::CFG_ENABLE:  en_reg  <= cfg_data[7:0];
                    nmcf_pkg::CFG_REPEAT:  rmt_reg <= cfg_data;
                    nmcf_pkg::CFG_TIMEOUT: nmt_reg <= cfg_data;
                    nmcf_pkg::CFG_WAITBS:  wbs_reg <= cfg_data;
                    nmcf_pkg::CFG_NOTIFY:  ntf_reg <= cfg_data[0];
                    default:               ntf_reg <= ntf_reg;
                endcase
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            op_reg  <= item.op;
            ch_reg  <= item.channel;
            now_reg <= item.now_ms[TW-1:0];
        end
        if (load)
            out_reg <= out_next;
    end

    // A request is never taken in the cycle right after another one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> item_stall)
        else $error("request accepted while the previous one is in progress");

    // State-change results appear only with notifications enabled.
    a_notify_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == nmcf_pkg::K_CHANGE) |-> ntf_reg)
        else $error("state change reported with notifications off");

    // A new result is never loaded over one that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_stall) |-> !load)
        else $error("result register overwritten while stalled");

    // The sequencer only goes back to idle once a final result is loaded.
    a_last_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg != nmcf_pkg::F_IDLE && fsm_next == nmcf_pkg::F_IDLE) |-> (load && out_next.last))
        else $error("request finished without a final result");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of network_management_channel_fsm.
// Depends on nmcf_pkg and the RTL; a built-in channel predictor checks every result.
`timescale 1ns / 100ps

module testbench;

    // Register index past the end of the register list.
    localparam logic [2:0] CFG_PAST_END = 3'd6;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    nmcf_pkg::nmcf_item_t item = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    nmcf_pkg::nmcf_res_t  res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    network_management_channel_fsm u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Requests waiting to be offered, and results the predictor expects.
    nmcf_pkg::nmcf_item_t pend_q[$];
    nmcf_pkg::nmcf_res_t  expected_q[$];
    int         errors = 0;
    bit         no_idle = 1'b0;
    int         hold_token = 0;

    // Predictor copy of the configuration registers.
    logic [7:0]  p_enable;
    logic [31:0] p_rep_time;
    logic [31:0] p_timeout;
    logic [31:0] p_wait_bs;
    logic        p_notify;

    // Predictor copy of the per-channel state and counters.
    nmcf_pkg::nmcf_cstate_t p_state[8];
    logic         p_req[8];
    logic         p_msg[8];
    logic [31:0]  p_entered[8];
    logic [31:0]  p_msg_time[8];
    logic [31:0]  p_wake[8];
    logic [31:0]  p_rep[8];
    logic [31:0]  p_tmo[8];
    logic [31:0]  p_sleep[8];
    logic [31:0]  p_tick_time;

    function automatic logic [1:0] mode_for(nmcf_pkg::nmcf_cstate_t s);
        case (s)
            nmcf_pkg::CS_BUS:  return nmcf_pkg::MD_BUS;
            nmcf_pkg::CS_PREP: return nmcf_pkg::MD_PREP;
            default:           return nmcf_pkg::MD_NET;
        endcase
    endfunction

    function automatic void clear_chan(int c);
        p_state[c] = nmcf_pkg::CS_BUS;
        p_req[c] = 1'b0;
        p_msg[c] = 1'b0;
        p_entered[c] = '0;
        p_msg_time[c] = '0;
        p_wake[c] = '0;
        p_rep[c] = '0;
        p_tmo[c] = '0;
        p_sleep[c] = '0;
    endfunction

    function automatic void push_res(int ch, nmcf_pkg::nmcf_kind_t k,
                                     nmcf_pkg::nmcf_cstate_t os,
                                     nmcf_pkg::nmcf_cstate_t ns, logic [1:0] md, logic rq,
                                     logic cr, logic lst);
        nmcf_pkg::nmcf_res_t r;
        r = '0;
        r.chan_out = ch[2:0];
        r.kind = k;
        r.old_state = os;
        r.new_state = ns;
        r.mode = md;
        r.requested = rq;
        r.cluster_ready = cr;
        r.last = lst;
        expected_q = {expected_q, r};
    endfunction

    // A state change, with its notification when notifications are on.
    function automatic void move_chan(int c, nmcf_pkg::nmcf_cstate_t ns, logic [31:0] stamp);
        nmcf_pkg::nmcf_cstate_t os;
        os = p_state[c];
        if (os == ns)
            return;
        p_state[c] = ns;
        p_entered[c] = stamp;
        if (p_notify)
            push_res(c, nmcf_pkg::K_CHANGE, os, ns, mode_for(ns), p_req[c], 1'b0, 1'b0);
    endfunction

    function automatic logic [31:0] elapsed_ms(logic [31:0] now, logic [31:0] then);
        return (now >= then) ? now - then : 32'd0;
    endfunction

    function automatic void tick_chan(int c, logic [31:0] now);
        logic [31:0] el;
        logic        rq;
        el = elapsed_ms(now, p_entered[c]);
        rq = p_req[c];
        case (p_state[c])
            nmcf_pkg::CS_BUS:
            begin
                if (rq || p_msg[c])
                begin
                    p_msg[c] = 1'b0;
                    p_wake[c]++;
                    move_chan(c, nmcf_pkg::CS_REPEAT, now);
                end
            end
            nmcf_pkg::CS_REPEAT:
            begin
                p_msg[c] = 1'b0;
                p_msg_time[c] = now;
                p_rep[c]++;
                if (el >= p_rep_time)
                    move_chan(c, rq ? nmcf_pkg::CS_NORMAL : nmcf_pkg::CS_READY, now);
            end
            nmcf_pkg::CS_NORMAL:
            begin
                if (p_msg[c])
                begin
                    p_msg[c] = 1'b0;
                    p_msg_time[c] = now;
                end
                if (!rq)
                    move_chan(c, nmcf_pkg::CS_READY, now);
                else if (elapsed_ms(now, p_msg_time[c]) >= p_timeout)
                begin
                    p_tmo[c]++;
                    move_chan(c, nmcf_pkg::CS_REPEAT, now);
                end
            end
            nmcf_pkg::CS_READY:
            begin
                if (rq || p_msg[c])
                begin
                    p_msg[c] = 1'b0;
                    move_chan(c, nmcf_pkg::CS_NORMAL, now);
                end
                else if (el >= p_timeout)
                    move_chan(c, nmcf_pkg::CS_PREP, now);
            end
            nmcf_pkg::CS_PREP:
            begin
                if (rq || p_msg[c])
                begin
                    p_msg[c] = 1'b0;
                    move_chan(c, nmcf_pkg::CS_REPEAT, now);
                end
                else if (el >= p_wait_bs)
                begin
                    p_sleep[c]++;
                    move_chan(c, nmcf_pkg::CS_BUS, now);
                end
            end
            default: ;
        endcase
    endfunction

    // Works out every result of one accepted request.
    function automatic void predict_results(nmcf_pkg::nmcf_item_t it);
        int                  c;
        logic                any_on;
        logic                all_sleep;
        nmcf_pkg::nmcf_res_t r;
        c = it.channel;
        any_on = 1'b0;
        all_sleep = 1'b1;
        if (it.op == nmcf_pkg::OP_TICK)
        begin
            p_tick_time = it.now_ms;
            for (int i = 0; i < 8; i++)
                if (p_enable[i])
                    tick_chan(i, it.now_ms);
            push_res(0, nmcf_pkg::K_ACK, nmcf_pkg::CS_BUS, nmcf_pkg::CS_BUS,
                     nmcf_pkg::MD_BUS, 1'b0, 1'b0, 1'b1);
            return;
        end
        if (it.op == nmcf_pkg::OP_CLUSTER)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (p_enable[i])
                begin
                    any_on = 1'b1;
                    if (p_state[i] > nmcf_pkg::CS_READY)
                        all_sleep = 1'b0;
                end
            end
            push_res(0, nmcf_pkg::K_ACK, nmcf_pkg::CS_BUS, nmcf_pkg::CS_BUS,
                     nmcf_pkg::MD_BUS, 1'b0, any_on && all_sleep, 1'b1);
            return;
        end
        if (!p_enable[c])
        begin
            push_res(c, nmcf_pkg::K_INVALID, nmcf_pkg::CS_BUS, nmcf_pkg::CS_BUS,
                     nmcf_pkg::MD_BUS, 1'b0, 1'b0, 1'b1);
            return;
        end
        if (it.op == nmcf_pkg::OP_STATUS)
        begin
            r = '0;
            r.chan_out = c[2:0];
            r.kind = nmcf_pkg::K_STATUS;
            r.old_state = p_state[c];
            r.new_state = p_state[c];
            r.mode = mode_for(p_state[c]);
            r.requested = p_req[c];
            r.wakeup_count = p_wake[c];
            r.repeat_count = p_rep[c];
            r.timeout_count = p_tmo[c];
            r.sleep_count = p_sleep[c];
            r.last = 1'b1;
            expected_q = {expected_q, r};
            return;
        end
        case (it.op)
            nmcf_pkg::OP_REQUEST: p_req[c] = 1'b1;
            nmcf_pkg::OP_RELEASE: p_req[c] = 1'b0;
            nmcf_pkg::OP_MSG:     p_msg[c] = 1'b1;
            nmcf_pkg::OP_RSLEEP:
            begin
                // Remote sleep only counts without a local request, from ready or normal.
                if (!p_req[c] && (p_state[c] == nmcf_pkg::CS_READY ||
                                  p_state[c] == nmcf_pkg::CS_NORMAL))
                    move_chan(c, nmcf_pkg::CS_PREP, p_tick_time);
            end
            default:
            begin
                if (p_state[c] != nmcf_pkg::CS_BUS)
                    move_chan(c, nmcf_pkg::CS_REPEAT, p_tick_time);
            end
        endcase
        push_res(c, nmcf_pkg::K_ACK, p_state[c], p_state[c], mode_for(p_state[c]), p_req[c],
                 1'b0, 1'b1);
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            nmcf_pkg::CFG_ENABLE:
            begin
                // Any channel whose enable bit flips starts over from reset.
                for (int c = 0; c < 8; c++)
                    if (val[c] != p_enable[c])
                        clear_chan(c);
                p_enable = val[7:0];
            end
            nmcf_pkg::CFG_REPEAT:  p_rep_time = val;
            nmcf_pkg::CFG_TIMEOUT: p_timeout = val;
            nmcf_pkg::CFG_WAITBS:  p_wait_bs = val;
            nmcf_pkg::CFG_NOTIFY:  p_notify = val[0];
            default: ;
        endcase
    endfunction

    initial
    begin
        p_enable = '0;
        p_rep_time = 32'd1500;
        p_timeout = 32'd2000;
        p_wait_bs = 32'd1500;
        p_notify = 1'b0;
        p_tick_time = '0;
        for (int c = 0; c < 8; c++)
            clear_chan(c);
    end

    // Request driver: offers the pending requests with random gaps between them.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic       nxt_valid;
        logic       slot_free;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            nxt_valid = item_valid;
            slot_free = !item_valid;
            if (item_valid && !item_stall)
            begin
                predict_results(item);
                slot_free = 1'b1;
                send_gap = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (slot_free)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    nxt_valid = 1'b0;
                end
                else if (pend_q.size() > 0)
                begin
                    item <= pend_q.pop_front();
                    nxt_valid = 1'b1;
                end
                else
                    nxt_valid = 1'b0;
            end
            item_valid <= nxt_valid;
        end
    end

    // Result monitor: random stalls per result, plus a long hold when asked.
    int recv_gap = 0;
    int long_left = 0;
    int hold_seen = 0;
    always @(posedge clk or negedge rst_n)
    begin
        nmcf_pkg::nmcf_res_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %p", $time, res);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, res);
                    end
                end
                recv_gap = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                long_left = 300;
            end
            if (long_left > 0)
            begin
                long_left--;
                res_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // Watchdog on cycles in which nothing moves on either channel.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 3000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_cfg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_req(nmcf_pkg::nmcf_op_t op, int ch, logic [31:0] now);
        nmcf_pkg::nmcf_item_t it;
        it.op = op;
        it.channel = ch[2:0];
        it.now_ms = now;
        pend_q = {pend_q, it};
    endtask

    // Waits until every request has gone out and all its results have come back.
    // The check runs on the falling edge, after the driver's updates have settled.
    task automatic drain();
        do
            @(negedge clk);
        while (pend_q.size() > 0 || expected_q.size() > 0 || item_valid);
        repeat (14) @(posedge clk);
    endtask

    // Random traffic: mostly rising time with ticks, sometimes jumps or steps back.
    logic [31:0] clock_ms = '0;
    task automatic random_reqs(int count);
        nmcf_pkg::nmcf_op_t op;
        int                 pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                op = nmcf_pkg::OP_TICK;
            else
                op = nmcf_pkg::nmcf_op_t'($urandom_range(0, 7));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                clock_ms = $urandom;
            else if (pick == 1)
                clock_ms = clock_ms - $urandom_range(0, 200);
            else
                clock_ms = clock_ms + $urandom_range(0, 150);
            add_req(op, $urandom_range(0, 7), clock_ms);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Straight out of reset no channel exists.
        add_req(nmcf_pkg::OP_REQUEST, 0, 0);
        add_req(nmcf_pkg::OP_STATUS, 7, 0);
        add_req(nmcf_pkg::OP_CLUSTER, 0, 0);
        add_req(nmcf_pkg::OP_TICK, 0, 32'hFFFF_FFFF);
        drain();

        write_reg(nmcf_pkg::CFG_ENABLE, 32'h0000_00FF);
        write_reg(nmcf_pkg::CFG_REPEAT, 32'd100);
        write_reg(nmcf_pkg::CFG_TIMEOUT, 32'd200);
        write_reg(nmcf_pkg::CFG_WAITBS, 32'd150);
        write_reg(nmcf_pkg::CFG_NOTIFY, 32'd1);
        write_reg(CFG_PAST_END, 32'hFFFF_FFFF);
        // Walk channel 0 through every state; channel 3 wakes on a message.
        add_req(nmcf_pkg::OP_CLUSTER, 0, 0);
        add_req(nmcf_pkg::OP_REQUEST, 0, 0);
        add_req(nmcf_pkg::OP_RSLEEP, 1, 0);
        add_req(nmcf_pkg::OP_REPEAT, 1, 0);
        add_req(nmcf_pkg::OP_TICK, 0, 10);
        add_req(nmcf_pkg::OP_CLUSTER, 0, 10);
        add_req(nmcf_pkg::OP_TICK, 0, 200);
        add_req(nmcf_pkg::OP_MSG, 0, 0);
        add_req(nmcf_pkg::OP_RSLEEP, 0, 0);
        add_req(nmcf_pkg::OP_REPEAT, 0, 0);
        add_req(nmcf_pkg::OP_TICK, 0, 350);
        add_req(nmcf_pkg::OP_RELEASE, 0, 0);
        add_req(nmcf_pkg::OP_TICK, 0, 400);
        add_req(nmcf_pkg::OP_RSLEEP, 0, 0);
        add_req(nmcf_pkg::OP_STATUS, 0, 0);
        add_req(nmcf_pkg::OP_TICK, 0, 300);
        add_req(nmcf_pkg::OP_TICK, 0, 32'hFFFF_FFFF);
        add_req(nmcf_pkg::OP_MSG, 3, 0);
        add_req(nmcf_pkg::OP_TICK, 0, 0);
        add_req(nmcf_pkg::OP_STATUS, 3, 0);
        add_req(nmcf_pkg::OP_STATUS, 0, 0);
        drain();

        // Random enables, small timers, no idling on either side.
        write_reg(nmcf_pkg::CFG_ENABLE, $urandom_range(1, 255));
        write_reg(nmcf_pkg::CFG_REPEAT, $urandom_range(0, 300));
        write_reg(nmcf_pkg::CFG_TIMEOUT, $urandom_range(0, 300));
        write_reg(nmcf_pkg::CFG_WAITBS, $urandom_range(0, 300));
        no_idle = 1'b1;
        random_reqs(40);
        drain();
        no_idle = 1'b0;

        // Zero timers, notifications off; the receiver holds off for a while.
        write_reg(nmcf_pkg::CFG_ENABLE, 32'h0000_00FF);
        write_reg(nmcf_pkg::CFG_REPEAT, 32'd0);
        write_reg(nmcf_pkg::CFG_TIMEOUT, 32'd0);
        write_reg(nmcf_pkg::CFG_WAITBS, 32'd0);
        write_reg(nmcf_pkg::CFG_NOTIFY, 32'd0);
        random_reqs(10);
        hold_token++;
        random_reqs(30);
        drain();

        // Largest timers, alternating channels; the sender pauses halfway.
        write_reg(nmcf_pkg::CFG_ENABLE, 32'h0000_0055);
        write_reg(nmcf_pkg::CFG_REPEAT, 32'hFFFF_FFFF);
        write_reg(nmcf_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(nmcf_pkg::CFG_WAITBS, 32'hFFFF_FFFF);
        write_reg(nmcf_pkg::CFG_NOTIFY, 32'd1);
        random_reqs(20);
        drain();
        random_reqs(20);
        drain();

        // Moderate timers on a new channel mix.
        write_reg(nmcf_pkg::CFG_ENABLE, 32'h0000_00AA);
        write_reg(nmcf_pkg::CFG_REPEAT, 32'd120);
        write_reg(nmcf_pkg::CFG_TIMEOUT, 32'd250);
        write_reg(nmcf_pkg::CFG_WAITBS, 32'd90);
        random_reqs(15);
        drain();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
